// File: rtl/dgp_pkg.sv
// ----------------------------------------------------------------------------
// dgp_pkg
// Shared constants, tables and types of the divided gate pattern generator.
// ----------------------------------------------------------------------------
package dgp_pkg;

   // lanes in use, at most MAX_LANES (the mask fields are MAX_LANES wide)
   localparam int LANES       = 4;
   localparam int MAX_LANES   = 4;

   localparam int RAND_W      = 6;
   localparam int CHANCE_W    = 6;
   localparam int PHASE_W     = 6;
   localparam int SEL_W       = 4;
   localparam int MASK_W      = 4;
   localparam int CV_W        = 12;
   localparam int COUNT_W     = 10;
   localparam int LEVEL_W     = 4;
   localparam int DIV_W       = 5;
   localparam int REM_W       = 4;
   localparam int TERM_W      = 7;

   // counter wraps at divisor << LIMIT_SHIFT
   localparam int LIMIT_SHIFT = 6;

   // dividend of the gate divider, consumed STEP_BITS bits per cycle
   localparam int X_W         = 12;
   localparam int STEP_BITS   = 4;
   localparam int DIV_STEPS   = X_W / STEP_BITS;
   localparam int STEP_CNT_W  = 2;

   localparam int PHASE_MAX   = 32;
   localparam int X_BIAS      = 160;
   localparam int LEVEL_TOP   = 10;
   localparam int LEVEL_SHIFT = 2;

   localparam int REQ_W       = MAX_LANES * RAND_W;
   localparam int RSP_W       = 2 * MASK_W + 2 * CV_W;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_IDX_W-1:0] REG_PHASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIXER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE   = 3'd4;

   typedef struct packed {
      logic clear;
      logic start;
      logic step;
      logic commit;
   } lane_ctrl_type;

   typedef struct packed {
      logic trig;
      logic gate;
      logic pass;
   } lane_result_type;

   localparam logic [DIV_W-1:0] DIV_TAB [16][MAX_LANES] = '{
      '{5'd1,  5'd2, 5'd3, 5'd4},  '{5'd1,  5'd2, 5'd4, 5'd8},
      '{5'd2,  5'd4, 5'd8, 5'd16}, '{5'd2,  5'd3, 5'd4, 5'd5},
      '{5'd2,  5'd3, 5'd5, 5'd7},  '{5'd2,  5'd3, 5'd5, 5'd8},
      '{5'd3,  5'd5, 5'd7, 5'd9},  '{5'd3,  5'd6, 5'd9, 5'd12},
      '{5'd12, 5'd9, 5'd6, 5'd3},  '{5'd9,  5'd7, 5'd5, 5'd3},
      '{5'd8,  5'd5, 5'd3, 5'd2},  '{5'd7,  5'd5, 5'd3, 5'd2},
      '{5'd5,  5'd4, 5'd3, 5'd2},  '{5'd16, 5'd8, 5'd4, 5'd2},
      '{5'd8,  5'd4, 5'd2, 5'd1},  '{5'd4,  5'd3, 5'd2, 5'd1}
   };

   localparam logic [MASK_W-1:0] MIX_TAB [16][2] = '{
      '{4'hF, 4'h1}, '{4'hE, 4'h1}, '{4'hC, 4'h3}, '{4'h8, 4'h7},
      '{4'hA, 4'h5}, '{4'h5, 4'hA}, '{4'h9, 4'h6}, '{4'h6, 4'h9},
      '{4'hF, 4'h3}, '{4'hF, 4'h6}, '{4'hF, 4'hC}, '{4'hF, 4'h8},
      '{4'h1, 4'hE}, '{4'h3, 4'hC}, '{4'h8, 4'hE}, '{4'h1, 4'hF}
   };

   localparam logic [CV_W-1:0] SCALE_TAB [16][16] = '{
      '{12'd0, 12'd68, 12'd136, 12'd170, 12'd238, 12'd306, 12'd375, 12'd409,
        12'd477, 12'd545, 12'd579, 12'd647, 12'd715, 12'd784, 12'd818, 12'd886},
      '{12'd0, 12'd68, 12'd102, 12'd170, 12'd238, 12'd306, 12'd340, 12'd409,
        12'd477, 12'd511, 12'd579, 12'd647, 12'd715, 12'd750, 12'd818, 12'd886},
      '{12'd0, 12'd34, 12'd102, 12'd170, 12'd238, 12'd272, 12'd340, 12'd409,
        12'd443, 12'd511, 12'd579, 12'd647, 12'd681, 12'd750, 12'd818, 12'd852},
      '{12'd0, 12'd68, 12'd136, 12'd204, 12'd238, 12'd306, 12'd375, 12'd409,
        12'd477, 12'd545, 12'd613, 12'd647, 12'd715, 12'd784, 12'd818, 12'd886},
      '{12'd0, 12'd68, 12'd136, 12'd170, 12'd238, 12'd306, 12'd340, 12'd409,
        12'd477, 12'd545, 12'd579, 12'd647, 12'd715, 12'd750, 12'd818, 12'd886},
      '{12'd0, 12'd68, 12'd136, 12'd170, 12'd238, 12'd306, 12'd340, 12'd409,
        12'd477, 12'd545, 12'd579, 12'd647, 12'd715, 12'd750, 12'd818, 12'd886},
      '{12'd0, 12'd34, 12'd102, 12'd170, 12'd204, 12'd272, 12'd340, 12'd409,
        12'd443, 12'd511, 12'd579, 12'd613, 12'd681, 12'd750, 12'd818, 12'd852},
      '{12'd0, 12'd34, 12'd68, 12'd102, 12'd136, 12'd170, 12'd204, 12'd238,
        12'd272, 12'd306, 12'd341, 12'd375, 12'd409, 12'd443, 12'd477, 12'd511},
      '{12'd0, 12'd68, 12'd136, 12'd204, 12'd272, 12'd341, 12'd409, 12'd477,
        12'd545, 12'd613, 12'd682, 12'd750, 12'd818, 12'd886, 12'd954, 12'd1022},
      '{12'd0, 12'd170, 12'd340, 12'd511, 12'd681, 12'd852, 12'd1022, 12'd1193,
        12'd1363, 12'd1534, 12'd1704, 12'd1875, 12'd2045, 12'd2215, 12'd2386,
        12'd2556},
      '{12'd0, 12'd238, 12'd477, 12'd715, 12'd954, 12'd1193, 12'd1431, 12'd1670,
        12'd1909, 12'd2147, 12'd2386, 12'd2625, 12'd2863, 12'd3102, 12'd3340,
        12'd3579},
      '{12'd0, 12'd17, 12'd34, 12'd51, 12'd68, 12'd85, 12'd102, 12'd119,
        12'd136, 12'd153, 12'd170, 12'd187, 12'd204, 12'd221, 12'd238, 12'd255},
      '{12'd0, 12'd8, 12'd17, 12'd25, 12'd34, 12'd42, 12'd51, 12'd59,
        12'd68, 12'd76, 12'd85, 12'd93, 12'd102, 12'd110, 12'd119, 12'd127},
      '{12'd0, 12'd61, 12'd122, 12'd163, 12'd245, 12'd327, 12'd429, 12'd491,
        12'd552, 12'd613, 12'd654, 12'd736, 12'd818, 12'd920, 12'd982, 12'd1105},
      '{12'd0, 12'd61, 12'd130, 12'd163, 12'd245, 12'd337, 12'd441, 12'd491,
        12'd552, 12'd621, 12'd654, 12'd736, 12'd828, 12'd932, 12'd982, 12'd1105},
      '{12'd0, 12'd272, 12'd545, 12'd818, 12'd1090, 12'd1363, 12'd1636, 12'd1909,
        12'd2181, 12'd2454, 12'd2727, 12'd3000, 12'd3272, 12'd3545, 12'd3818,
        12'd4091}
   };

endpackage

// File: rtl/dgp_lane.sv
// ----------------------------------------------------------------------------
// dgp_lane
// One gate lane: tick counter, iterative gate divider, level and trigger.
// ----------------------------------------------------------------------------
module dgp_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  dgp_pkg::lane_ctrl_type           ctrl,
   input  logic [dgp_pkg::DIV_W-1:0]        divisor,
   input  logic [dgp_pkg::TERM_W-1:0]       phase_term,
   input  logic [dgp_pkg::RAND_W-1:0]       rand_value,
   input  logic [dgp_pkg::CHANCE_W-1:0]     chance,
   output dgp_pkg::lane_result_type         result
);

   logic [dgp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [dgp_pkg::COUNT_W:0]   cnt_inc, cnt_limit, cnt_new;
   logic [dgp_pkg::X_W-1:0]     x_start, dividend_ff, dividend_in;
   logic [dgp_pkg::REM_W-1:0]   rem_ff, rem_in, step_rem;
   logic                        q_ff, q_in, step_q;
   logic                        pass_ff, pass_in;
   logic [dgp_pkg::LEVEL_W-1:0] last_level_ff, last_level_in, level;
   logic [dgp_pkg::DIV_W-1:0]   span;

   assign cnt_inc   = {1'b0, count_ff} + (dgp_pkg::COUNT_W+1)'(1);
   assign cnt_limit = (dgp_pkg::COUNT_W+1)'(divisor) << dgp_pkg::LIMIT_SHIFT;
   assign cnt_new   = (cnt_inc >= cnt_limit) ? '0 : cnt_inc;
   assign x_start   = dgp_pkg::X_W'(cnt_new) + dgp_pkg::X_W'(dgp_pkg::X_BIAS)
                      - dgp_pkg::X_W'(phase_term);

   // restoring division, STEP_BITS quotient bits per cycle, msb first
   always_comb begin
      logic [dgp_pkg::REM_W:0]   trial;
      logic [dgp_pkg::REM_W-1:0] r;
      logic                      q;
      r = rem_ff;
      q = q_ff;
      for (int i = 0; i < dgp_pkg::STEP_BITS; i++) begin
         trial = {r, dividend_ff[dgp_pkg::X_W-1-i]};
         if (trial >= divisor) begin
            r = dgp_pkg::REM_W'(trial - divisor);
            q = 1'b1;
         end else begin
            r = dgp_pkg::REM_W'(trial);
            q = 1'b0;
         end
      end
      step_rem = r;
      step_q   = q;
   end

   // q_ff is the quotient lsb, rem_ff the remainder, once all steps are done
   assign span  = dgp_pkg::DIV_W'(divisor - dgp_pkg::DIV_W'(1) - dgp_pkg::DIV_W'(rem_ff));
   assign level = q_ff ? dgp_pkg::LEVEL_W'(dgp_pkg::LEVEL_TOP)
                         - dgp_pkg::LEVEL_W'(span >> dgp_pkg::LEVEL_SHIFT)
                       : '0;

   always_comb begin
      count_in      = count_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      pass_in       = pass_ff;
      last_level_in = last_level_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.start) begin
         count_in = dgp_pkg::COUNT_W'(cnt_new);
      end
      if (ctrl.start) begin
         dividend_in = x_start;
         rem_in      = '0;
         q_in        = 1'b0;
         pass_in     = chance < rand_value;
      end else if (ctrl.step) begin
         dividend_in = dividend_ff << dgp_pkg::STEP_BITS;
         rem_in      = step_rem;
         q_in        = step_q;
      end
      if (ctrl.commit) begin
         last_level_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         last_level_ff <= '0;
      end else begin
         count_ff      <= count_in;
         last_level_ff <= last_level_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      pass_ff     <= pass_in;
   end

   assign result.trig = pass_ff && (level != last_level_ff);
   assign result.gate = |level;
   assign result.pass = pass_ff;

endmodule

// File: rtl/dgp_merge.sv
// ----------------------------------------------------------------------------
// dgp_merge
// Combines lane results into masks and mixer codes, scale lookup, output reg.
// ----------------------------------------------------------------------------
module dgp_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  dgp_pkg::lane_result_type       results [dgp_pkg::LANES],
   input  logic [dgp_pkg::MASK_W-1:0]     mask_a,
   input  logic [dgp_pkg::MASK_W-1:0]     mask_b,
   input  logic [dgp_pkg::SEL_W-1:0]      scale_sel,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dgp_pkg::RSP_W-1:0]      rsp_tdata
);

   logic [dgp_pkg::MASK_W-1:0] trig_v, gate_v, code_a, code_b;
   logic [dgp_pkg::CV_W-1:0]   cv_a, cv_b;
   logic                       valid_ff, valid_in;
   logic [dgp_pkg::RSP_W-1:0]  data_ff, data_in;

   always_comb begin
      trig_v = '0;
      gate_v = '0;
      code_a = '0;
      code_b = '0;
      for (int l = 0; l < dgp_pkg::LANES; l++) begin
         trig_v[l] = results[l].trig;
         gate_v[l] = results[l].gate;
         code_a[l] = results[l].pass && results[l].gate && mask_a[l];
         code_b[l] = results[l].gate && mask_b[l];
      end
   end

   assign cv_a = dgp_pkg::SCALE_TAB[scale_sel][code_a];
   assign cv_b = dgp_pkg::SCALE_TAB[scale_sel][code_b];

   assign data_in  = load ? {cv_b, cv_a, gate_v, trig_v} : data_ff;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// File: rtl/divided_gate_pattern_cv_generator.sv
// ----------------------------------------------------------------------------
// divided_gate_pattern_cv_generator
// Four divided gate lanes with chance gating, triggers and two stepped CVs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     four 6-bit random values
//  rsp      out        rsp_tvalid/tready     trig, gate masks, cv_a, cv_b
//  csr      in         csr_we                index + 6-bit data, write only
//
//  a request first loads each lane's divider in the accept cycle, then the
//  run state steps the 4-bit-per-cycle gate divider, and the result is
//  committed while the next request is accepted.
//  the output register holds one result; a stalled rsp side holds the
//  commit and so req_tready, while a request is still taken in the idle
//  state with a result waiting in the output register.
//  reset is synchronous and clears configuration, counters and levels.
// ----------------------------------------------------------------------------
module divided_gate_pattern_cv_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dgp_pkg::REQ_W-1:0]         req_tdata,  // rand_lane0..rand_lane3
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dgp_pkg::RSP_W-1:0]         rsp_tdata,  // trig_mask, gate_mask, cv_a, cv_b
   input  logic                              csr_we,
   input  logic [dgp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dgp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [dgp_pkg::STEP_CNT_W-1:0] STEP_LAST =
      dgp_pkg::STEP_CNT_W'(dgp_pkg::DIV_STEPS - 1);

   logic [1:0]                         state_ff, state_in;
   logic [dgp_pkg::STEP_CNT_W-1:0]     step_ff, step_in;
   logic [dgp_pkg::PHASE_W-1:0]        phase_ff;
   logic [dgp_pkg::SEL_W-1:0]          divset_ff, mixset_ff, scale_ff;
   logic [dgp_pkg::CHANCE_W-1:0]       chance_ff;
   logic [dgp_pkg::PHASE_W-1:0]        phase_clamp;
   logic                               out_free, start, step, commit;
   dgp_pkg::lane_ctrl_type             lane_ctrl;
   dgp_pkg::lane_result_type           results [dgp_pkg::LANES];
   logic [dgp_pkg::TERM_W-1:0]         phase_term [dgp_pkg::LANES];

   assign out_free = !rsp_tvalid || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      start      = 1'b0;
      step       = 1'b0;
      commit     = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               start    = 1'b1;
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            step    = 1'b1;
            step_in = step_ff + dgp_pkg::STEP_CNT_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               commit     = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  start    = 1'b1;
                  state_in = ST_RUN;
                  step_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         divset_ff <= '0;
         chance_ff <= '0;
         mixset_ff <= '0;
         scale_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dgp_pkg::REG_PHASE:   phase_ff  <= csr_wdata;
            dgp_pkg::REG_DIVISOR: divset_ff <= dgp_pkg::SEL_W'(csr_wdata);
            dgp_pkg::REG_CHANCE:  chance_ff <= csr_wdata;
            dgp_pkg::REG_MIXER:   mixset_ff <= dgp_pkg::SEL_W'(csr_wdata);
            dgp_pkg::REG_SCALE:   scale_ff  <= dgp_pkg::SEL_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // phase steps above the top of the range act as the top
   assign phase_clamp = (phase_ff > dgp_pkg::PHASE_W'(dgp_pkg::PHASE_MAX))
                        ? dgp_pkg::PHASE_W'(dgp_pkg::PHASE_MAX) : phase_ff;

   assign lane_ctrl.clear  = csr_we && (csr_index == dgp_pkg::REG_DIVISOR);
   assign lane_ctrl.start  = start;
   assign lane_ctrl.step   = step;
   assign lane_ctrl.commit = commit;

   for (genvar l = 0; l < dgp_pkg::LANES; l++) begin : g_lane
      assign phase_term[l] = dgp_pkg::TERM_W'(phase_clamp * l);

      dgp_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .divisor    (dgp_pkg::DIV_TAB[divset_ff][l]),
         .phase_term (phase_term[l]),
         .rand_value (req_tdata[l*dgp_pkg::RAND_W +: dgp_pkg::RAND_W]),
         .chance     (chance_ff),
         .result     (results[l])
      );
   end

   dgp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (commit),
      .results    (results),
      .mask_a     (dgp_pkg::MIX_TAB[mixset_ff][0]),
      .mask_b     (dgp_pkg::MIX_TAB[mixset_ff][1]),
      .scale_sel  (scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/dgp_checker.sv
// ----------------------------------------------------------------------------
// dgp_checker
// Port-level checks of the divided gate pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module dgp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dgp_pkg::RSP_W-1:0]         rsp_tdata
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the divider is busy, and req_tready low, through its run steps after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request taken while divider busy");

   // with no gated lane both mixer codes are zero and so are both cvs
   a_no_gate_no_cv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:4] == 4'd0) |->
         (rsp_tdata[19:8] == 12'd0) && (rsp_tdata[31:20] == 12'd0))
      else $error("cv nonzero with empty gate mask");

endmodule

bind divided_gate_pattern_cv_generator dgp_checker u_dgp_checker (.*);

// File: tb/sv/dgp_pattern_checker.sv
// ----------------------------------------------------------------------------
// dgp_pattern_checker
// Watches the req, rsp and csr ports of the divided gate pattern generator,
// predicts the trig/gate masks and both CV values for every accepted request
// and compares them, in order, with the accepted results.
// ----------------------------------------------------------------------------
module dgp_pattern_checker
   import dgp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // rand_lane0..rand_lane3
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,  // trig_mask, gate_mask, cv_a, cv_b
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    checked
);

   // highest field first, so the struct maps straight onto rsp_tdata
   typedef struct packed {
      logic [11:0] cv_b;
      logic [11:0] cv_a;
      logic [3:0]  gate;
      logic [3:0]  trig;
   } cv_pattern_type;

   localparam int DIV_ROWS [16][4] = '{
      '{1, 2, 3, 4},   '{1, 2, 4, 8},  '{2, 4, 8, 16}, '{2, 3, 4, 5},
      '{2, 3, 5, 7},   '{2, 3, 5, 8},  '{3, 5, 7, 9},  '{3, 6, 9, 12},
      '{12, 9, 6, 3},  '{9, 7, 5, 3},  '{8, 5, 3, 2},  '{7, 5, 3, 2},
      '{5, 4, 3, 2},   '{16, 8, 4, 2}, '{8, 4, 2, 1},  '{4, 3, 2, 1}
   };

   localparam logic [3:0] MIX_ROWS [16][2] = '{
      '{4'hF, 4'h1}, '{4'hE, 4'h1}, '{4'hC, 4'h3}, '{4'h8, 4'h7},
      '{4'hA, 4'h5}, '{4'h5, 4'hA}, '{4'h9, 4'h6}, '{4'h6, 4'h9},
      '{4'hF, 4'h3}, '{4'hF, 4'h6}, '{4'hF, 4'hC}, '{4'hF, 4'h8},
      '{4'h1, 4'hE}, '{4'h3, 4'hC}, '{4'h8, 4'hE}, '{4'h1, 4'hF}
   };

   localparam logic [11:0] CV_STEPS [16][16] = '{
      '{0, 68, 136, 170, 238, 306, 375, 409, 477, 545, 579, 647, 715, 784, 818, 886},
      '{0, 68, 102, 170, 238, 306, 340, 409, 477, 511, 579, 647, 715, 750, 818, 886},
      '{0, 34, 102, 170, 238, 272, 340, 409, 443, 511, 579, 647, 681, 750, 818, 852},
      '{0, 68, 136, 204, 238, 306, 375, 409, 477, 545, 613, 647, 715, 784, 818, 886},
      '{0, 68, 136, 170, 238, 306, 340, 409, 477, 545, 579, 647, 715, 750, 818, 886},
      '{0, 68, 136, 170, 238, 306, 340, 409, 477, 545, 579, 647, 715, 750, 818, 886},
      '{0, 34, 102, 170, 204, 272, 340, 409, 443, 511, 579, 613, 681, 750, 818, 852},
      '{0, 34, 68, 102, 136, 170, 204, 238, 272, 306, 341, 375, 409, 443, 477, 511},
      '{0, 68, 136, 204, 272, 341, 409, 477, 545, 613, 682, 750, 818, 886, 954, 1022},
      '{0, 170, 340, 511, 681, 852, 1022, 1193, 1363, 1534, 1704, 1875, 2045, 2215,
        2386, 2556},
      '{0, 238, 477, 715, 954, 1193, 1431, 1670, 1909, 2147, 2386, 2625, 2863, 3102,
        3340, 3579},
      '{0, 17, 34, 51, 68, 85, 102, 119, 136, 153, 170, 187, 204, 221, 238, 255},
      '{0, 8, 17, 25, 34, 42, 51, 59, 68, 76, 85, 93, 102, 110, 119, 127},
      '{0, 61, 122, 163, 245, 327, 429, 491, 552, 613, 654, 736, 818, 920, 982, 1105},
      '{0, 61, 130, 163, 245, 337, 441, 491, 552, 621, 654, 736, 828, 932, 982, 1105},
      '{0, 272, 545, 818, 1090, 1363, 1636, 1909, 2181, 2454, 2727, 3000, 3272, 3545,
        3818, 4091}
   };

   logic [5:0]  phase_r, chance_r;
   logic [3:0]  div_r, mix_r, scale_r;
   logic [9:0]  lane_cnt [4];
   logic [3:0]  last_lvl [4];
   cv_pattern_type due_patterns [$];
   cv_pattern_type got, want;

   // advances the lane counters and levels by one tick
   function automatic cv_pattern_type next_pattern(input logic [REQ_W-1:0] rnd);
      cv_pattern_type r;
      int          ph, d, cnt, x, lvl;
      logic [3:0]  code_a, code_b, mask_a, mask_b;
      r      = '0;
      code_a = '0;
      code_b = '0;
      ph     = (phase_r > 6'd32) ? 32 : int'(phase_r);
      mask_a = MIX_ROWS[mix_r][0];
      mask_b = MIX_ROWS[mix_r][1];
      for (int ln = 0; ln < LANES; ln++) begin
         d   = DIV_ROWS[div_r][ln];
         cnt = int'(lane_cnt[ln]) + 1;
         if (cnt >= d * 64)
            cnt = 0;
         lane_cnt[ln] = COUNT_W'(cnt);
         x   = cnt + 160 - ph * ln;
         lvl = ((x / d) % 2 == 1) ? 10 - ((d - 1 - (x % d)) >> 2) : 0;
         if (chance_r < rnd[ln*RAND_W +: RAND_W]) begin
            if (lvl != 0 && mask_a[ln])
               code_a[ln] = 1'b1;
            if (int'(last_lvl[ln]) != lvl)
               r.trig[ln] = 1'b1;
         end
         if (lvl != 0) begin
            r.gate[ln] = 1'b1;
            if (mask_b[ln])
               code_b[ln] = 1'b1;
         end
         last_lvl[ln] = LEVEL_W'(lvl);
      end
      r.cv_a = CV_STEPS[scale_r][code_a];
      r.cv_b = CV_STEPS[scale_r][code_b];
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_r    = '0;
         chance_r   = '0;
         div_r      = '0;
         mix_r      = '0;
         scale_r    = '0;
         for (int i = 0; i < 4; i++) begin
            lane_cnt[i] = '0;
            last_lvl[i] = '0;
         end
         due_patterns.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PHASE:   phase_r  = csr_wdata;
               REG_DIVISOR: begin
                  div_r = csr_wdata[3:0];
                  for (int i = 0; i < 4; i++)
                     lane_cnt[i] = '0;
               end
               REG_CHANCE:  chance_r = csr_wdata;
               REG_MIXER:   mix_r    = csr_wdata[3:0];
               REG_SCALE:   scale_r  = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_patterns.size() == 0) begin
               $display("%0t: result with no request waiting, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = due_patterns.pop_front();
               check_field("trig_mask", int'(want.trig), int'(got.trig));
               check_field("gate_mask", int'(want.gate), int'(got.gate));
               check_field("cv_a", int'(want.cv_a), int'(got.cv_a));
               check_field("cv_b", int'(want.cv_b), int'(got.cv_b));
               checked++;
            end
         end
         if (req_tvalid && req_tready)
            due_patterns.push_back(next_pattern(req_tdata));
      end
      pending = due_patterns.size();
   end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the divided gate pattern generator: directed
// requests at field and register extremes, then random register settings
// with random requests, random idling on both sides and a long rsp hold-off.
// ----------------------------------------------------------------------------
module tb;
   import dgp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS = 100;
   localparam int RAND_PHASES = 8;

   // indexes that map to no register
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;   // rand_lane0..rand_lane3
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;         // trig_mask, gate_mask, cv_a, cv_b
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count, pending, checked;
   int sent         = 0;
   int settings     = 0;
   int quiet_cycles = 0;
   bit jitter_on    = 1'b1;
   bit hold_request = 1'b0;

   always #10 clock = ~clock;

   divided_gate_pattern_cv_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dgp_pattern_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, or a long hold-off when asked for
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= (jitter_on && $urandom_range(0, 99) < 32) ? 1'b0 : 1'b1;
         end
      end
   end

   // offers one tick request, returns at the falling edge after acceptance
   task automatic send_tick(input logic [REQ_W-1:0] rnd);
      while (jitter_on && $urandom_range(0, 99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rnd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // the divisor write also clears the lane counters, so it is optional
   task automatic reconfigure(input int ph, input int dv, input int ch, input int mx,
                              input int sc, input bit touch_div);
      drain();
      write_reg(REG_PHASE, CSR_DATA_W'(ph));
      if (touch_div)
         write_reg(REG_DIVISOR, CSR_DATA_W'(dv));
      write_reg(REG_CHANCE, CSR_DATA_W'(ch));
      write_reg(REG_MIXER, CSR_DATA_W'(mx));
      write_reg(REG_SCALE, CSR_DATA_W'(sc));
      csr_we <= 1'b0;
      settings++;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: chance zero, so only nonzero random values pass
      send_tick('0);
      send_tick('1);
      send_tick({4{6'h2A}});
      send_tick({4{6'h15}});

      // phase above range, chance 33, a divisor row with the largest divisor, top mixer and scale
      reconfigure(63, 13, 33, 15, 15, 1'b1);
      @(negedge clock);
      write_reg(REG_UNUSED_LO, 6'h3F);
      write_reg(REG_UNUSED_HI, 6'h3F);
      csr_we <= 1'b0;
      send_tick('1);
      send_tick('0);
      send_tick({4{6'd33}});
      send_tick({4{6'd34}});

      // nothing can pass
      reconfigure(32, 14, 63, 0, 0, 1'b1);
      repeat (3) send_tick('1);

      reconfigure(0, 0, 0, 12, 9, 1'b1);
      repeat (10) send_tick(REQ_W'($urandom()));

      for (int p = 0; p < RAND_PHASES; p++) begin
         reconfigure($urandom_range(0, 63), $urandom_range(0, 15),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 40),
                     $urandom_range(0, 15), $urandom_range(0, 15),
                     (p % 2 == 0));
         jitter_on = (p != 4);
         if (p == 2)
            hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_tick(REQ_W'($urandom()));
      end

      jitter_on = 1'b1;
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);

      $display("sent %0d tick requests under %0d register settings, %0d results compared",
               sent, settings, checked);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
